>>> hw/rtl/cbe_pkg.sv
// Package for the cubic Bezier easing block: fixed-point constants and helpers.
// Depends on nothing; used by cbe_divider and cubic_bezier_easing.
package cbe_pkg;

   localparam int unsigned MaxIterationsDefault = 10;
   localparam logic signed [31:0] Q28One = 32'sh1000_0000;
   localparam logic signed [31:0] DerivMin = 32'sd256;
   localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SatMin = -32'sh7FFF_FFFF - 32'sd1;

   // Register indexes
   localparam logic [1:0] RegCtrl1X = 2'd0;
   localparam logic [1:0] RegCtrl1Y = 2'd1;
   localparam logic [1:0] RegCtrl2X = 2'd2;
   localparam logic [1:0] RegCtrl2Y = 2'd3;

   // Saturate a 66-bit value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'(SatMax)) r = SatMax;
      else if (v < 66'(SatMin)) r = SatMin;
      else r = v[31:0];
      return r;
   endfunction

   // Q2.14 to Q4.28
   function automatic logic signed [31:0] to_q28(input logic signed [15:0] v);
      return {{2{v[15]}}, v, 14'd0};
   endfunction

endpackage

>>> hw/rtl/cbe_divider.sv
// Restoring divider: trunc(num * 2^28 / den), saturated to 32 bits, one bit a cycle.
// Depends on cbe_pkg.
module cbe_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);

   // |num| * 2^28 < 2^60, quotient up to 60 bits
   logic [59:0] dividend_ff, dividend_in;
   logic [59:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] abs_num;
   logic [31:0] abs_den;
   logic signed [61:0] sq;

   assign abs_num = num[31] ? 32'(-num) : num;
   assign abs_den = den[31] ? 32'(-den) : den;
   assign trial = {rem_ff, dividend_ff[59]} - {1'b0, den_ff};

   // one quotient bit per cycle
   always_comb begin
      dividend_in = dividend_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         dividend_in = {abs_num[31:0], 28'd0};
         q_in = '0;
         rem_in = '0;
         den_in = abs_den;
         neg_in = num[31] ^ den[31];
         cnt_in = 6'd60;
         run_in = 1'b1;
      end else if (run_ff) begin
         dividend_in = {dividend_ff[58:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            q_in = {q_ff[58:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], dividend_ff[59]};
            q_in = {q_ff[58:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign sq = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
   assign quot = cbe_pkg::sat32(66'(sq));
   assign done = done_ff;

endmodule

>>> hw/rtl/cubic_bezier_easing.sv
// Cubic Bezier easing curve evaluator, top level.
// Depends on cbe_pkg and cbe_divider.
//
// Usage: pulse req_start with req_time_in while rsp_busy is low. The block
// solves x(u) = t by Newton steps from u = t, then returns y(u) on
// rsp_eased_out for one cycle, marked by rsp_strobe. Values are Q2.14.
// Control points are written through csr_write_enable / csr_index /
// csr_write_data while the block is idle; all four indexes are decoded.
// One shared 32x32 multiplier under a small sequencer computes each
// polynomial. Each Newton step is a curve and derivative evaluation
// followed by a division in the bit-serial divider; a closing curve
// evaluation of y gives the result. A t at or below 0 or at or above 1
// skips all evaluations; otherwise up to MAX_ITERATIONS Newton steps
// run. One item at a time: rsp_busy is high from the transfer until the
// result cycle. Reset returns the control points to (0,0) and (1,1) and
// idles the sequencer. The receiver cannot stall; each result is shown
// for exactly one cycle.
module cubic_bezier_easing #(
   parameter int unsigned MAX_ITERATIONS = cbe_pkg::MaxIterationsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   input  logic signed [15:0] req_time_in,
   output logic               rsp_busy,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_eased_out,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   localparam int IterW = $clog2(MAX_ITERATIONS + 1);

   // sequencer states
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StEval = 3'd1;
   localparam logic [2:0] StDiv  = 3'd2;
   localparam logic [2:0] StOut  = 3'd3;

   // micro-op step codes in an evaluation
   localparam logic [4:0] OpOm     = 5'd0;
   localparam logic [4:0] OpOmOm   = 5'd1;
   localparam logic [4:0] OpOmU    = 5'd2;
   localparam logic [4:0] OpUU     = 5'd3;
   localparam logic [4:0] OpA1     = 5'd4;
   localparam logic [4:0] OpA2     = 5'd5;
   localparam logic [4:0] OpB1     = 5'd6;
   localparam logic [4:0] OpB2     = 5'd7;
   localparam logic [4:0] OpC1     = 5'd8;
   localparam logic [4:0] OpSum1   = 5'd9;
   localparam logic [4:0] OpSum2   = 5'd10;
   localparam logic [4:0] OpDa     = 5'd11;
   localparam logic [4:0] OpDsub1  = 5'd12;
   localparam logic [4:0] OpDb     = 5'd13;
   localparam logic [4:0] OpDsub2  = 5'd14;
   localparam logic [4:0] OpDc     = 5'd15;
   localparam logic [4:0] OpDsum   = 5'd16;
   localparam logic [4:0] OpDsum2  = 5'd17;
   localparam logic [4:0] OpDecide = 5'd18;

   logic signed [31:0] c1x_ff, c1y_ff, c2x_ff, c2y_ff;
   logic [2:0]  state_ff, state_in;
   logic [4:0]  op_ff, op_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic        final_ff, final_in;
   logic signed [31:0] t_ff, t_in, u_ff, u_in;
   logic signed [31:0] om_ff, om_in, omom_ff, omu_ff, uu_ff;
   logic signed [31:0] acc_ff, acc_in, tmp_ff, tmp_in, d_ff, d_in;
   logic signed [31:0] omom_in, omu_in, uu_in;
   logic signed [15:0] res_ff, res_in;
   logic        strobe_ff, strobe_in;
   logic signed [31:0] ma, mb, mres;
   logic signed [63:0] prod;
   logic signed [31:0] c1, c2;
   logic        div_start;
   logic        div_done;
   logic signed [31:0] div_q;
   logic signed [31:0] diff;
   logic signed [33:0] rnd;
   logic signed [33:0] ad;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= '0;
         c1y_ff <= '0;
         c2x_ff <= cbe_pkg::Q28One;
         c2y_ff <= cbe_pkg::Q28One;
      end else if (csr_write_enable) begin
         case (csr_index)
            cbe_pkg::RegCtrl1X: c1x_ff <= cbe_pkg::to_q28(csr_write_data);
            cbe_pkg::RegCtrl1Y: c1y_ff <= cbe_pkg::to_q28(csr_write_data);
            cbe_pkg::RegCtrl2X: c2x_ff <= cbe_pkg::to_q28(csr_write_data);
            cbe_pkg::RegCtrl2Y: c2y_ff <= cbe_pkg::to_q28(csr_write_data);
            default: ;
         endcase
      end
   end

   assign c1 = final_ff ? c1y_ff : c1x_ff;
   assign c2 = final_ff ? c2y_ff : c2x_ff;

   // shared multiplier: floor shift by 28 then saturate
   assign prod = ma * mb;
   assign mres = cbe_pkg::sat32(66'(prod >>> 28));

   // operand selection for the shared multiplier
   always_comb begin
      ma = om_ff;
      mb = om_ff;
      case (op_ff)
         OpOmOm: begin ma = om_ff; mb = om_ff; end
         OpOmU:  begin ma = om_ff; mb = u_ff; end
         OpUU:   begin ma = u_ff; mb = u_ff; end
         OpA1:   begin ma = omom_ff; mb = u_ff; end
         OpA2:   begin ma = tmp_ff; mb = c1; end
         OpB1:   begin ma = omu_ff; mb = u_ff; end
         OpB2:   begin ma = tmp_ff; mb = c2; end
         OpC1:   begin ma = uu_ff; mb = u_ff; end
         OpDa:   begin ma = omom_ff; mb = c1x_ff; end
         OpDb:   begin ma = omu_ff; mb = tmp_ff; end
         OpDc:   begin ma = uu_ff; mb = tmp_ff; end
         default: ;
      endcase
   end

   assign diff = cbe_pkg::sat32(66'(acc_ff) - 66'(t_ff));
   assign ad = (d_ff < 0) ? -34'(d_ff) : 34'(d_ff);
   assign div_start = (state_ff == StEval) && (op_ff == OpDecide) && !final_ff
                      && (iter_ff != IterW'(MAX_ITERATIONS))
                      && (ad >= 34'(cbe_pkg::DerivMin));
   assign rnd = (34'(acc_ff) + 34'sd8192) >>> 14;

   cbe_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (diff),
      .den   (d_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      iter_in = iter_ff;
      final_in = final_ff;
      t_in = t_ff;
      u_in = u_ff;
      om_in = om_ff;
      omom_in = omom_ff;
      omu_in = omu_ff;
      uu_in = uu_ff;
      acc_in = acc_ff;
      tmp_in = tmp_ff;
      d_in = d_ff;
      res_in = res_ff;
      strobe_in = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req_start) begin
               if (req_time_in <= 16'sd0) begin
                  res_in = 16'sd0;
                  state_in = StOut;
               end else if (req_time_in >= 16'sd16384) begin
                  res_in = 16'sd16384;
                  state_in = StOut;
               end else begin
                  t_in = cbe_pkg::to_q28(req_time_in);
                  u_in = cbe_pkg::to_q28(req_time_in);
                  iter_in = '0;
                  final_in = 1'b0;
                  op_in = OpOm;
                  state_in = StEval;
               end
            end
         end
         StEval: begin
            op_in = op_ff + 5'd1;
            case (op_ff)
               OpOm:   om_in = cbe_pkg::sat32(66'(cbe_pkg::Q28One) - 66'(u_ff));
               OpOmOm: omom_in = mres;
               OpOmU:  omu_in = mres;
               OpUU:   uu_in = mres;
               OpA1:   tmp_in = mres;
               OpA2:   acc_in = cbe_pkg::sat32(66'(mres) * 66'sd3);
               OpB1:   tmp_in = mres;
               OpB2:   tmp_in = cbe_pkg::sat32(66'(mres) * 66'sd3);
               OpC1: begin
                  acc_in = cbe_pkg::sat32(66'(acc_ff) + 66'(tmp_ff));
                  tmp_in = mres;
               end
               OpSum1: begin
                  acc_in = cbe_pkg::sat32(66'(acc_ff) + 66'(tmp_ff));
                  if (final_ff) op_in = OpDecide;
               end
               OpSum2: ;
               OpDa:   d_in = cbe_pkg::sat32(66'(mres) * 66'sd3);
               OpDsub1: tmp_in = cbe_pkg::sat32(66'(c2x_ff) - 66'(c1x_ff));
               OpDb:   tmp_in = cbe_pkg::sat32(66'(mres) * 66'sd6);
               OpDsub2: begin
                  d_in = cbe_pkg::sat32(66'(d_ff) + 66'(tmp_ff));
                  tmp_in = cbe_pkg::sat32(66'(cbe_pkg::Q28One) - 66'(c2x_ff));
               end
               OpDc:   tmp_in = cbe_pkg::sat32(66'(mres) * 66'sd3);
               OpDsum: d_in = cbe_pkg::sat32(66'(d_ff) + 66'(tmp_ff));
               OpDsum2: ;
               OpDecide: begin
                  if (final_ff) begin
                     if (rnd > 34'sd32767) res_in = 16'sh7FFF;
                     else if (rnd < -34'sd32768) res_in = -16'sh8000;
                     else res_in = rnd[15:0];
                     state_in = StOut;
                  end else if (div_start) begin
                     state_in = StDiv;
                  end else begin
                     final_in = 1'b1;
                     op_in = OpOm;
                  end
               end
               default: state_in = StIdle;
            endcase
         end
         StDiv: begin
            if (div_done) begin
               u_in = cbe_pkg::sat32(66'(u_ff) - 66'(div_q));
               iter_in = iter_ff + IterW'(1);
               op_in = OpOm;
               state_in = StEval;
            end
         end
         StOut: begin
            strobe_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      iter_ff <= iter_in;
      final_ff <= final_in;
      t_ff <= t_in;
      u_ff <= u_in;
      om_ff <= om_in;
      omom_ff <= omom_in;
      omu_ff <= omu_in;
      uu_ff <= uu_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      d_ff <= d_in;
      res_ff <= res_in;
      if (reset) begin
         state_ff <= StIdle;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_busy = (state_ff != StIdle);
   assign rsp_strobe = strobe_ff;
   assign rsp_eased_out = res_ff;

endmodule

>>> test/tb_cubic_bezier_easing.sv
// Testbench for cubic_bezier_easing: drives time values and control points, and checks
// every eased result against a fixed-point Newton-solver model kept in this file.
// Depends on cbe_pkg and on the cubic_bezier_easing RTL.
`timescale 1ns / 100ps

module tb_cubic_bezier_easing;

   localparam int unsigned Iterations = cbe_pkg::MaxIterationsDefault;
   localparam int unsigned StallLimit = 20000;

   logic               clock;
   logic               reset;
   logic               req_start;
   logic signed [15:0] req_time_in;
   logic               rsp_busy;
   logic               rsp_strobe;
   logic signed [15:0] rsp_eased_out;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [15:0]        csr_write_data;

   // Shadow copy of the control points, Q2.14
   logic signed [15:0] point_x1, point_y1, point_x2, point_y2;

   logic signed [15:0] eased_queue[$];
   int unsigned        mismatches;
   int unsigned        results_seen;
   int unsigned        stall_cycles;
   int unsigned        sender_idle_pct;

   cubic_bezier_easing i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_start       (req_start),
      .req_time_in     (req_time_in),
      .rsp_busy        (rsp_busy),
      .rsp_strobe      (rsp_strobe),
      .rsp_eased_out   (rsp_eased_out),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Q4.28 arithmetic with saturation
   function automatic int clamp32(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(32'sh8000_0000) - 0) begin
         if (v < -64'sd2147483648) return -32'sd2147483648;
      end
      return int'(v);
   endfunction

   function automatic int fx_mul(input int a, input int b);
      return clamp32((longint'(a) * longint'(b)) >>> 28);
   endfunction

   function automatic int fx_sub(input int a, input int b);
      return clamp32(longint'(a) - longint'(b));
   endfunction

   function automatic int fx_add(input int a, input int b);
      return clamp32(longint'(a) + longint'(b));
   endfunction

   function automatic int fx_scale(input int k, input int a);
      return clamp32(longint'(k) * longint'(a));
   endfunction

   function automatic int widen(input logic signed [15:0] v);
      return int'(v) * 16384;
   endfunction

   // Curve polynomial for one axis
   function automatic int curve_at(input int u, input int c1, input int c2);
      int om;
      om = fx_sub(32'sh1000_0000, u);
      return fx_add(fx_add(fx_scale(3, fx_mul(fx_mul(fx_mul(om, om), u), c1)),
                           fx_scale(3, fx_mul(fx_mul(fx_mul(om, u), u), c2))),
                    fx_mul(fx_mul(u, u), u));
   endfunction

   function automatic int slope_at(input int u, input int c1, input int c2);
      int om;
      om = fx_sub(32'sh1000_0000, u);
      return fx_add(fx_add(fx_scale(3, fx_mul(fx_mul(om, om), c1)),
                           fx_scale(6, fx_mul(fx_mul(om, u), fx_sub(c2, c1)))),
                    fx_scale(3, fx_mul(fx_mul(u, u), fx_sub(32'sh1000_0000, c2))));
   endfunction

   function automatic logic signed [15:0] eased_value(input logic signed [15:0] t14);
      int     t, u, x1, x2, slope, diff;
      longint mag, r;
      if (t14 <= 0) return 16'sd0;
      if (t14 >= 16384) return 16'sd16384;
      t  = widen(t14);
      x1 = widen(point_x1);
      x2 = widen(point_x2);
      u  = t;
      for (int i = 0; i < Iterations; i++) begin
         slope = slope_at(u, x1, x2);
         mag = slope < 0 ? -longint'(slope) : longint'(slope);
         // flat derivative: stop and evaluate y at the current u
         if (mag < 256) break;
         diff = fx_sub(curve_at(u, x1, x2), t);
         u = fx_sub(u, clamp32((longint'(diff) * 64'sd268435456) / longint'(slope)));
      end
      r = (longint'(curve_at(u, widen(point_y1), widen(point_y2))) + 8192) >>> 14;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // Result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            results_seen++;
            if (eased_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result %0d", rsp_eased_out);
            end else begin
               logic signed [15:0] want;
               want = eased_queue.pop_front();
               if (rsp_eased_out !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: eased_out expected %0d, got %0d", want, rsp_eased_out);
               end
            end
         end
         if (rsp_strobe || (req_start && !rsp_busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Send one time value; the start stays high until the next call or a drain
   task automatic send_time(input logic signed [15:0] t14);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      while (rsp_busy) begin
         req_start <= 1'b0;
         @(negedge clock);
      end
      req_start   <= 1'b1;
      req_time_in <= t14;
      @(posedge clock);
      eased_queue.push_back(eased_value(t14));
      @(negedge clock);
   endtask

   task automatic drain();
      req_start <= 1'b0;
      while (eased_queue.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic signed [15:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         cbe_pkg::RegCtrl1X: point_x1 = v;
         cbe_pkg::RegCtrl1Y: point_y1 = v;
         cbe_pkg::RegCtrl2X: point_x2 = v;
         default:            point_y2 = v;
      endcase
      @(negedge clock);
   endtask

   task automatic set_points(input logic signed [15:0] x1, input logic signed [15:0] y1,
                             input logic signed [15:0] x2, input logic signed [15:0] y2);
      drain();
      write_reg(cbe_pkg::RegCtrl1X, x1);
      write_reg(cbe_pkg::RegCtrl1Y, y1);
      write_reg(cbe_pkg::RegCtrl2X, x2);
      write_reg(cbe_pkg::RegCtrl2Y, y2);
   endtask

   // Reset-value curve: the clamp regions of t, their edges and interior times
   task automatic test_time_extremes();
      logic signed [15:0] corners[10] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd8192,
                                          16'sd16383, 16'sd16384, 16'sd16385, 16'sd32767,
                                          16'sd4096};
      foreach (corners[i]) send_time(corners[i]);
   endtask

   // Derivative vanishes near u = 0 when both x points sit at zero
   task automatic test_flat_slope();
      set_points(16'sd0, 16'sd9000, 16'sd0, 16'sd12000);
      send_time(16'sd1);
      send_time(16'sd2);
      send_time(16'sd100);
      send_time(16'sd16000);
   endtask

   // Control points at both ends of their range
   task automatic test_point_extremes();
      set_points(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_time(16'sd1);
      send_time(16'sd8192);
      send_time(16'sd16383);
      set_points(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_time(16'sd1);
      send_time(16'sd8192);
      send_time(16'sd16383);
   endtask

   // Random times over several curves and sender gap patterns
   task automatic test_random_curves();
      logic signed [15:0] t14;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_points(16'sd4096, 16'sd1638, 16'sd4096, 16'sd16384);
            1: set_points(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
            2: set_points(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
            default: begin
               if ($urandom_range(1))
                  set_points(16'($urandom_range(16384)), 16'($urandom),
                             16'($urandom_range(16384)), 16'($urandom));
               else
                  set_points(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
         endcase
         sender_idle_pct = (phase % 3 == 0) ? 24 : (phase % 3 == 1) ? 67 : 0;
         for (int n = 0; n < 290; n++) begin
            if ($urandom_range(9) < 8) t14 = 16'($urandom_range(16383, 1));
            else t14 = 16'($urandom);
            send_time(t14);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_start        = 1'b0;
      req_time_in      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      point_x1 = 16'sd0;
      point_y1 = 16'sd0;
      point_x2 = 16'sd16384;
      point_y2 = 16'sd16384;
      mismatches      = 0;
      results_seen    = 0;
      stall_cycles    = 0;
      sender_idle_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_time_extremes();
      test_flat_slope();
      test_point_extremes();
      test_random_curves();
      drain();

      $display("Covered %0d results: clamped times, flat slopes, extreme and random curves,",
               results_seen);
      $display("with sender gaps of 24, 67 and 0 percent.");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
